// ===== hw/rtl/opss_pkg.sv =====
// Package: shared types, request and status codes, random word step
`timescale 1ns / 1ps
package opss_pkg;

    localparam int DEPTH_DEF       = 64;
    localparam int HANDLE_BITS_DEF = 16;
    localparam int PADDR_W         = 3;
    localparam int RNG_W           = 32;

    // request codes
    localparam logic [3:0] REQ_ADD_TOP     = 4'd0;
    localparam logic [3:0] REQ_ADD_BOTTOM  = 4'd1;
    localparam logic [3:0] REQ_ADD_RANDOM  = 4'd2;
    localparam logic [3:0] REQ_DRAW_TOP    = 4'd3;
    localparam logic [3:0] REQ_DRAW_BOTTOM = 4'd4;
    localparam logic [3:0] REQ_DRAW_RANDOM = 4'd5;
    localparam logic [3:0] REQ_REMOVE      = 4'd6;
    localparam logic [3:0] REQ_CONTAINS    = 4'd7;
    localparam logic [3:0] REQ_PEEK_N      = 4'd8;
    localparam logic [3:0] REQ_READ_AT     = 4'd9;
    localparam logic [3:0] REQ_DRAIN       = 4'd10;
    localparam logic [3:0] REQ_CLEAR       = 4'd11;
    localparam logic [3:0] REQ_SHUFFLE     = 4'd12;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_RANGE     = 3'd4;

    // register byte address bit value that selects the seed register
    localparam logic ADDR_SEED = 1'b0;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [15:0] handle;
        logic [6:0]  position;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] item;
        logic [6:0]  fill;
        logic        last;
    } rsp_t;

    // xorshift 13/17/5 step
    function automatic logic [RNG_W-1:0] xorshift32(input logic [RNG_W-1:0] x);
        logic [RNG_W-1:0] t;
        t = x ^ (x << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

// ===== hw/rtl/ordered_pile_store_with_shuffle.sv =====
// Top level: ordered pile of handles with add, draw, search, stream and shuffle requests
//
// Requests enter on req (valid/ready) and results leave on rsp (valid/ready); each
// transaction on req gives one result, or one per entry for peek and drain, and the
// final result of a request carries last. The block takes one request at a time:
// req_ready is high only while the sequencer is idle.
// Clear, read and plain adds at the top move no entries; an insert or removal moves
// entries one at a time through the slot memory, a read and a write each; a search
// reads the slots one by one; random picks wait for the bit-serial remainder unit; a
// shuffle runs the remainder unit and then two reads and two writes per swap. Peek and
// drain give one result per entry.
// A stalled receiver holds the sequencer at its next result; the result register lets
// a new request be taken while the last result of the previous one still waits.
// Reset empties the pile and loads 1 into the random word; the slot memory is not
// cleared. A write to the seed register over the APB port reloads the random word
// (zero loads 1); reads return the value last written.
`timescale 1ns / 1ps
module ordered_pile_store_with_shuffle #(
    parameter int DEPTH       = opss_pkg::DEPTH_DEF,
    parameter int HANDLE_BITS = opss_pkg::HANDLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_ready,
    input  opss_pkg::req_t                req,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output opss_pkg::rsp_t                rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [opss_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import opss_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 7) ? CW : 7;
    localparam int HW = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_RNG     = 21'h000002,
        S_MOD     = 21'h000004,
        S_SHUP_RD = 21'h000008,
        S_SHUP_WR = 21'h000010,
        S_PLACE   = 21'h000020,
        S_TAKE_RD = 21'h000040,
        S_TAKE_WR = 21'h000080,
        S_SHDN_RD = 21'h000100,
        S_SHDN_WR = 21'h000200,
        S_SCAN_RD = 21'h000400,
        S_SCAN_CM = 21'h000800,
        S_STR_RD  = 21'h001000,
        S_STR_OUT = 21'h002000,
        S_READ_RD = 21'h004000,
        S_READ_WT = 21'h008000,
        S_SWP_RDI = 21'h010000,
        S_SWP_RDJ = 21'h020000,
        S_SWP_WRI = 21'h040000,
        S_SWP_WRJ = 21'h080000,
        S_DONE    = 21'h100000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   ptr_reg, ptr_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   lim_reg, lim_next;
    logic [RNG_W-1:0] rng_reg, rng_next;
    logic [31:0]     seed_reg, seed_next;
    logic [2:0]      status_reg, status_next;
    logic [15:0]     item_reg, item_next;
    logic [3:0]      type_reg, type_next;
    logic [HW-1:0]   hnd_reg, hnd_next;
    logic [HW-1:0]   swap_reg, swap_next;
    rsp_t            rsp_reg, rsp_next;
    logic            rsp_valid_reg, rsp_valid_next;

    // slot memory
    logic [HW-1:0]   mem [DEPTH];
    logic [HW-1:0]   mem_q;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [HW-1:0]   mem_wd;

    // remainder unit
    logic            mod_start, mod_busy, mod_done;
    logic [CW-1:0]   mod_div, mod_rem;
    logic [RNG_W-1:0] rng_step;

    logic            take;
    logic            can_emit;
    logic            cfg_wr;
    logic [XW-1:0]   pos_x, cnt_x;
    logic [15:0]     q_ext;
    logic [CW-1:0]   str_addr;

    assign take      = req_valid && req_ready;
    assign can_emit  = !rsp_valid_reg || rsp_ready;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == ADDR_SEED);
    assign pos_x     = XW'(req.position);
    assign cnt_x     = XW'(count_reg);
    assign rng_step  = xorshift32(rng_reg);
    assign str_addr  = (type_reg == REQ_DRAIN) ? ptr_reg : (count_reg - CW'(1) - ptr_reg);

    always_comb
    begin
        q_ext         = '0;
        q_ext[HW-1:0] = mem_q;
    end

    opss_mod #(.DW(CW)) u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mod_start),
        .dividend  (rng_step),
        .divisor   (mod_div),
        .busy      (mod_busy),
        .done      (mod_done),
        .remainder (mod_rem)
    );

    // divisor of the random pick
    always_comb
    begin
        case (type_reg)
            REQ_ADD_RANDOM:  mod_div = count_reg + CW'(1);
            REQ_DRAW_RANDOM: mod_div = count_reg;
            default:         mod_div = ptr_reg + CW'(1);
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        rng_next       = rng_reg;
        seed_next      = seed_reg;
        status_next    = status_reg;
        item_next      = item_reg;
        type_next      = type_reg;
        hnd_next       = hnd_reg;
        swap_next      = swap_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        mod_start      = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = ptr_reg[AW-1:0];
        mem_wd         = mem_q;
        mem_re         = 1'b0;
        mem_ra         = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    type_next   = req.req_type;
                    hnd_next    = req.handle[HW-1:0];
                    status_next = ST_OK;
                    item_next   = '0;
                    ptr_next    = count_reg;
                    state_next  = S_DONE;
                    case (req.req_type)
                        REQ_ADD_TOP, REQ_ADD_BOTTOM, REQ_ADD_RANDOM:
                        begin
                            if (count_reg == CW'(DEPTH))
                                status_next = ST_FULL;
                            else if (req.req_type == REQ_ADD_TOP || count_reg == '0)
                            begin
                                idx_next   = count_reg;
                                state_next = S_SHUP_RD;
                            end
                            else if (req.req_type == REQ_ADD_BOTTOM)
                            begin
                                idx_next   = '0;
                                state_next = S_SHUP_RD;
                            end
                            else
                                state_next = S_RNG;
                        end
                        REQ_DRAW_TOP, REQ_DRAW_BOTTOM, REQ_DRAW_RANDOM:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else if (req.req_type == REQ_DRAW_TOP)
                            begin
                                idx_next   = count_reg - CW'(1);
                                state_next = S_TAKE_RD;
                            end
                            else if (req.req_type == REQ_DRAW_BOTTOM)
                            begin
                                idx_next   = '0;
                                state_next = S_TAKE_RD;
                            end
                            else
                                state_next = S_RNG;
                        end
                        REQ_REMOVE, REQ_CONTAINS:
                        begin
                            ptr_next   = '0;
                            state_next = S_SCAN_RD;
                        end
                        REQ_PEEK_N:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else if (req.position != '0)
                            begin
                                lim_next   = (pos_x < cnt_x) ? CW'(req.position) : count_reg;
                                ptr_next   = '0;
                                state_next = S_STR_RD;
                            end
                        end
                        REQ_READ_AT:
                        begin
                            if (pos_x >= cnt_x)
                                status_next = ST_RANGE;
                            else
                            begin
                                idx_next   = CW'(req.position);
                                state_next = S_READ_RD;
                            end
                        end
                        REQ_DRAIN:
                        begin
                            if (count_reg == '0)
                                status_next = ST_EMPTY;
                            else
                            begin
                                lim_next   = count_reg;
                                count_next = '0;
                                ptr_next   = '0;
                                state_next = S_STR_RD;
                            end
                        end
                        REQ_CLEAR:
                            count_next = '0;
                        REQ_SHUFFLE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                ptr_next   = count_reg - CW'(1);
                                state_next = S_RNG;
                            end
                        end
                        default:
                            status_next = ST_OK;
                    endcase
                end
            end
            // step the generator and start the remainder
            S_RNG:
            begin
                rng_next   = rng_step;
                mod_start  = 1'b1;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (mod_done)
                begin
                    idx_next = mod_rem;
                    case (type_reg)
                        REQ_ADD_RANDOM:  state_next = S_SHUP_RD;
                        REQ_DRAW_RANDOM: state_next = S_TAKE_RD;
                        default:         state_next = S_SWP_RDI;
                    endcase
                end
            end
            // open a gap at idx by moving entries up
            S_SHUP_RD:
            begin
                if (ptr_reg == idx_reg)
                    state_next = S_PLACE;
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = AW'(ptr_reg - CW'(1));
                    state_next = S_SHUP_WR;
                end
            end
            S_SHUP_WR:
            begin
                mem_we     = 1'b1;
                ptr_next   = ptr_reg - CW'(1);
                state_next = S_SHUP_RD;
            end
            S_PLACE:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg[AW-1:0];
                mem_wd     = hnd_reg;
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            // pick up the drawn entry, then close the gap
            S_TAKE_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = idx_reg[AW-1:0];
                state_next = S_TAKE_WR;
            end
            S_TAKE_WR:
            begin
                item_next  = q_ext;
                ptr_next   = idx_reg;
                state_next = S_SHDN_RD;
            end
            S_SHDN_RD:
            begin
                if (ptr_reg + CW'(1) >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_ra     = AW'(ptr_reg + CW'(1));
                    state_next = S_SHDN_WR;
                end
            end
            S_SHDN_WR:
            begin
                mem_we     = 1'b1;
                ptr_next   = ptr_reg + CW'(1);
                state_next = S_SHDN_RD;
            end
            // search bottom up for the handle
            S_SCAN_RD:
            begin
                if (ptr_reg == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_SCAN_CM;
                end
            end
            S_SCAN_CM:
            begin
                if (mem_q == hnd_reg)
                    state_next = (type_reg == REQ_REMOVE) ? S_SHDN_RD : S_DONE;
                else
                begin
                    ptr_next   = ptr_reg + CW'(1);
                    state_next = S_SCAN_RD;
                end
            end
            // peek and drain: one result per entry
            S_STR_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = str_addr[AW-1:0];
                state_next = S_STR_OUT;
            end
            S_STR_OUT:
            begin
                if (can_emit)
                begin
                    rsp_next.status = ST_OK;
                    rsp_next.item   = q_ext;
                    rsp_next.fill   = 7'(count_reg);
                    rsp_next.last   = (ptr_reg + CW'(1) == lim_reg);
                    rsp_valid_next  = 1'b1;
                    ptr_next        = ptr_reg + CW'(1);
                    state_next      = (ptr_reg + CW'(1) == lim_reg) ? S_IDLE : S_STR_RD;
                end
            end
            S_READ_RD:
            begin
                mem_re     = 1'b1;
                mem_ra     = idx_reg[AW-1:0];
                state_next = S_READ_WT;
            end
            S_READ_WT:
            begin
                item_next  = q_ext;
                state_next = S_DONE;
            end
            // swap slot ptr with slot idx
            S_SWP_RDI:
            begin
                mem_re     = 1'b1;
                state_next = S_SWP_RDJ;
            end
            S_SWP_RDJ:
            begin
                swap_next  = mem_q;
                mem_re     = 1'b1;
                mem_ra     = idx_reg[AW-1:0];
                state_next = S_SWP_WRI;
            end
            S_SWP_WRI:
            begin
                mem_we     = 1'b1;
                state_next = S_SWP_WRJ;
            end
            S_SWP_WRJ:
            begin
                mem_we     = 1'b1;
                mem_wa     = idx_reg[AW-1:0];
                mem_wd     = swap_reg;
                ptr_next   = ptr_reg - CW'(1);
                state_next = (ptr_reg == CW'(1)) ? S_DONE : S_RNG;
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    rsp_next.status = status_reg;
                    rsp_next.item   = item_reg;
                    rsp_next.fill   = 7'(count_reg);
                    rsp_next.last   = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // seed write reloads the generator
        if (cfg_wr)
        begin
            seed_next = pwdata;
            rng_next  = (pwdata == '0) ? RNG_W'(1) : pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rng_reg       <= RNG_W'(1);
            seed_reg      <= 32'd1;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rng_reg       <= rng_next;
            seed_reg      <= seed_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        lim_reg    <= lim_next;
        status_reg <= status_next;
        item_reg   <= item_next;
        type_reg   <= type_next;
        hnd_reg    <= hnd_next;
        swap_reg   <= swap_next;
        rsp_reg    <= rsp_next;
    end

    // slot memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (mem_re)
            mem_q <= mem[mem_ra];
    end

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == ADDR_SEED) ? seed_reg : 32'd0;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");
    a_idle_mod: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mod_busy)
        else $error("remainder unit busy while idle");
    a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
        (take && count_reg == CW'(DEPTH) &&
         (req.req_type == REQ_ADD_TOP || req.req_type == REQ_ADD_BOTTOM ||
          req.req_type == REQ_ADD_RANDOM)) |=> count_reg == $past(count_reg))
        else $error("add to full pile changed the count");
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

endmodule

// ===== hw/rtl/opss_mod.sv =====
// Iterative remainder unit: 32-bit dividend modulo a narrow divisor, one bit a cycle
`timescale 1ns / 1ps
module opss_mod #(
    parameter int DW = 7
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [31:0]   dividend,
    input  logic [DW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] remainder
);
    import opss_pkg::*;

    logic [RNG_W-1:0] dvd_reg, dvd_next;
    logic [DW-1:0]    rem_reg, rem_next;
    logic [DW-1:0]    div_reg, div_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DW:0]      trial;
    logic [DW:0]      diff;

    // restoring step: bring down one dividend bit, subtract if it fits
    assign trial = {rem_reg, dvd_reg[RNG_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = (trial >= {1'b0, div_reg}) ? diff[DW-1:0] : trial[DW-1:0];
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(RNG_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign remainder = rem_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) busy_reg |-> !start)
        else $error("remainder unit restarted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("remainder unit done while busy");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && div_reg != '0) |-> rem_reg < div_reg)
        else $error("remainder not below divisor");

endmodule
